/* rtl/mer_pkg.sv */
// Package for the midpoint ellipse rasterizer.
// Shared constants and the request struct between sequencer and pixel emitter.
// No dependencies.
`default_nettype none

package mer_pkg;

  // default radius width
  localparam int COORD_BITS_DEF = 10;

  // fixed field widths
  localparam int CENTER_W = 10;
  localparam int PIX_W    = 12;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  // reset values of the centre registers
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd512;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd384;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // sequencer to emitter handoff
  typedef struct packed {
    logic valid;   // a new point is offered
    logic done;    // point closes the ellipse
  } mer_req_t;

endpackage

`default_nettype wire

/* rtl/mer_in_if.sv */
// Input channel of the ellipse rasterizer: valid/ready plus command and radii.
// Depends on mer_pkg for the default radius width.
`default_nettype none

interface mer_in_if import mer_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] radius_x;
  logic [COORD_BITS-1:0] radius_y;

  modport source (output valid, command, radius_x, radius_y, input ready);
  modport sink   (input valid, command, radius_x, radius_y, output ready);
endinterface

`default_nettype wire

/* rtl/mer_out_if.sv */
// Result channel of the ellipse rasterizer: valid/ready plus one pixel.
// Depends on mer_pkg for the pixel width.
`default_nettype none

interface mer_out_if import mer_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    last_of_step;
  logic                    ellipse_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  output ready);
endinterface

`default_nettype wire

/* rtl/mer_mul.sv */
// Shared unsigned multiplier with a registered product.
// Depends on mer_pkg for the default operand width; no submodules.
`default_nettype none

module mer_mul import mer_pkg::*; #(
  parameter int OP_W = 2 * COORD_BITS_DEF + 4
) (
  input  wire logic                  clk,
  input  wire logic [OP_W-1:0]       op_a,
  input  wire logic [OP_W-1:0]       op_b,
  output      logic [2*OP_W-1:0]     prod_r
);

  // registered product: it lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* rtl/mer_emit.sv */
// Pixel emitter: mirrors one point into four pixels behind an output register.
// Depends on mer_pkg and mer_out_if.
`default_nettype none

module mer_emit import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CENTER_W-1:0]   center_x,
  input  wire logic [CENTER_W-1:0]   center_y,
  input  wire mer_req_t              req,
  input  wire logic [COORD_BITS:0]   point_x,
  input  wire logic [COORD_BITS-1:0] point_y,
  output      logic                  req_ready,
  mer_out_if.source                  out_if
);

  logic                  busy_r, busy_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [COORD_BITS:0]   x_r;
  logic [COORD_BITS-1:0] y_r;
  logic                  done_r;

  logic                    valid_r, valid_nxt;
  logic signed [PIX_W-1:0] px_r;
  logic signed [PIX_W-1:0] py_r;
  logic                    last_r;
  logic                    odone_r;

  logic             load;
  logic [PIX_W-1:0] x_pos, x_neg, y_pos, y_neg;

  assign req_ready = !busy_r;
  assign load      = busy_r && (!valid_r || out_if.ready);

  // mirrored coordinates, wrapped to the pixel width
  always_comb begin
    x_pos = PIX_W'(center_x) + PIX_W'(x_r);
    x_neg = PIX_W'(center_x) - PIX_W'(x_r);
    y_pos = PIX_W'(center_y) + PIX_W'(y_r);
    y_neg = PIX_W'(center_y) - PIX_W'(y_r);
  end

  // control: pixel counter and output valid
  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (out_if.ready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      cnt_nxt   = cnt_r + 2'd1;
      if (cnt_r == 2'd3) busy_nxt = 1'b0;
    end
    if (req.valid && req_ready) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // point capture and pixel payload
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      x_r    <= point_x;
      y_r    <= point_y;
      done_r <= req.done;
    end
    if (load) begin
      last_r  <= (cnt_r == 2'd3);
      odone_r <= done_r;
      case (cnt_r)
        2'd0: begin
          px_r <= $signed(x_pos);
          py_r <= $signed(y_pos);
        end
        2'd1: begin
          px_r <= $signed(x_neg);
          py_r <= $signed(y_neg);
        end
        2'd2: begin
          px_r <= $signed(x_neg);
          py_r <= $signed(y_pos);
        end
        default: begin
          px_r <= $signed(x_pos);
          py_r <= $signed(y_neg);
        end
      endcase
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.pixel_x      = px_r;
  assign out_if.pixel_y      = py_r;
  assign out_if.last_of_step = last_r;
  assign out_if.ellipse_done = odone_r;

endmodule

`default_nettype wire

/* rtl/mer_core.sv */
// Sequencer and decision datapath of the ellipse rasterizer.
// Depends on mer_pkg, mer_in_if and the shared multiplier mer_mul.
`default_nettype none

module mer_core import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mer_in_if.sink                     in_if,
  output      mer_req_t              req,
  output      logic [COORD_BITS:0]   point_x,
  output      logic [COORD_BITS-1:0] point_y,
  input  wire logic                  emit_ready
);

  localparam int N   = COORD_BITS;
  localparam int XW  = N + 1;          // point x
  localparam int SQW = 2 * N;          // squared radii
  localparam int TW  = 3 * N + 3;      // 2*ry^2*x and 2*rx^2*y
  localparam int MW  = 2 * N + 4;      // multiplier operand
  localparam int PW  = 2 * MW;         // multiplier product
  localparam int DW  = 4 * N + 6;      // decision, 4x the published value

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ST0  = 4'd1;   // rx*rx
  localparam logic [3:0] S_ST1  = 4'd2;   // ry*ry
  localparam logic [3:0] S_ST2  = 4'd3;   // rx^2*ry
  localparam logic [3:0] S_ST3  = 4'd4;   // initial decision
  localparam logic [3:0] S_CHK  = 4'd5;   // region test
  localparam logic [3:0] S_R0   = 4'd6;   // t*t
  localparam logic [3:0] S_R1   = 4'd7;   // ry^2*t^2
  localparam logic [3:0] S_R2   = 4'd8;   // u*u
  localparam logic [3:0] S_R3   = 4'd9;   // rx^2*u^2
  localparam logic [3:0] S_R4   = 4'd10;  // rx^2*ry^2
  localparam logic [3:0] S_R5   = 4'd11;  // region-2 decision ready
  localparam logic [3:0] S_UPD  = 4'd12;  // one step of the walk
  localparam logic [3:0] S_EMIT = 4'd13;  // hand point to emitter

  logic [3:0]           state_r, state_nxt;
  logic                 active_r, active_nxt;
  logic                 reg2_r, reg2_nxt;
  logic                 done_r, done_nxt;
  logic [N-1:0]         rx_r, rx_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [N-1:0]         y_r, y_nxt;
  logic [SQW-1:0]       a2_r, a2_nxt;
  logic [SQW-1:0]       b2_r, b2_nxt;
  logic [TW-1:0]        tx_r, tx_nxt;
  logic [TW-1:0]        ty_r, ty_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;

  logic [MW-1:0] op_a, op_b;
  logic [PW-1:0] prod_r;

  logic                 accept;
  logic [TW-1:0]        tx_inc, ty_dec;
  logic signed [DW-1:0] s_a2, s_b2, s_txi, s_tyd, s_prod;

  mer_mul #(.OP_W(MW)) u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_ST0: begin op_a = MW'(rx_r);              op_b = MW'(rx_r); end
      S_ST1: begin op_a = MW'(y_r);               op_b = MW'(y_r); end
      S_ST2: begin op_a = MW'(a2_r);              op_b = MW'(y_r); end
      S_R0:  begin op_a = MW'({x_r, 1'b1});       op_b = MW'({x_r, 1'b1}); end
      S_R1:  begin op_a = MW'(b2_r);              op_b = prod_r[MW-1:0]; end
      S_R2:  begin op_a = MW'(y_r - N'(1));       op_b = MW'(y_r - N'(1)); end
      S_R3:  begin op_a = MW'(a2_r);              op_b = prod_r[MW-1:0]; end
      S_R4:  begin op_a = MW'(a2_r);              op_b = MW'(b2_r); end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // step increments
  always_comb begin
    tx_inc = tx_r + (TW'(b2_r) << 1);
    ty_dec = ty_r - (TW'(a2_r) << 1);
    s_a2   = $signed(DW'(a2_r));
    s_b2   = $signed(DW'(b2_r));
    s_txi  = $signed(DW'(tx_inc));
    s_tyd  = $signed(DW'(ty_dec));
    s_prod = $signed(prod_r[DW-1:0]);
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    reg2_nxt   = reg2_r;
    done_nxt   = done_r;
    rx_nxt     = rx_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    a2_nxt     = a2_r;
    b2_nxt     = b2_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    dec_nxt    = dec_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_if.command == CMD_START) begin
            rx_nxt     = in_if.radius_x;
            y_nxt      = in_if.radius_y;
            x_nxt      = '0;
            tx_nxt     = '0;
            reg2_nxt   = 1'b0;
            active_nxt = (in_if.radius_y != '0);
            state_nxt  = S_ST0;
          end else if (active_r) begin
            if (y_r == '0) active_nxt = 1'b0;
            else state_nxt = S_CHK;
          end
        end
      end
      S_ST0: state_nxt = S_ST1;
      S_ST1: begin
        a2_nxt    = prod_r[SQW-1:0];
        state_nxt = S_ST2;
      end
      S_ST2: begin
        b2_nxt    = prod_r[SQW-1:0];
        state_nxt = S_ST3;
      end
      S_ST3: begin
        // 4*ry^2 - 4*rx^2*ry + rx^2
        ty_nxt    = TW'(prod_r) << 1;
        dec_nxt   = (s_b2 <<< 2) - (s_prod <<< 2) + s_a2;
        state_nxt = S_IDLE;
      end
      S_CHK: begin
        if (!reg2_r && (tx_r >= ty_r)) state_nxt = S_R0;
        else state_nxt = S_UPD;
      end
      S_R0: state_nxt = S_R1;
      S_R1: state_nxt = S_R2;
      S_R2: begin
        dec_nxt   = s_prod;
        state_nxt = S_R3;
      end
      S_R3: state_nxt = S_R4;
      S_R4: begin
        dec_nxt   = dec_r + (s_prod <<< 2);
        state_nxt = S_R5;
      end
      S_R5: begin
        dec_nxt   = dec_r - (s_prod <<< 2);
        reg2_nxt  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!reg2_r) begin
          x_nxt  = x_r + XW'(1);
          tx_nxt = tx_inc;
          if (dec_r < 0) begin
            dec_nxt = dec_r + ((s_b2 + s_txi) <<< 2);
          end else begin
            y_nxt   = y_r - N'(1);
            ty_nxt  = ty_dec;
            dec_nxt = dec_r + ((s_b2 + s_txi - s_tyd) <<< 2);
          end
        end else begin
          y_nxt  = y_r - N'(1);
          ty_nxt = ty_dec;
          if (dec_r > 0) begin
            dec_nxt = dec_r + ((s_a2 - s_tyd) <<< 2);
          end else begin
            x_nxt   = x_r + XW'(1);
            tx_nxt  = tx_inc;
            dec_nxt = dec_r + ((s_a2 - s_tyd + s_txi) <<< 2);
          end
        end
        done_nxt = (y_nxt == '0);
        if (y_nxt == '0) active_nxt = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      reg2_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      reg2_r   <= reg2_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    done_r <= done_nxt;
    rx_r   <= rx_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    dec_r  <= dec_nxt;
  end

  assign req.valid = (state_r == S_EMIT);
  assign req.done  = done_r;
  assign point_x   = x_r;
  assign point_y   = y_r;

endmodule

`default_nettype wire

/* rtl/midpoint_ellipse_rasterizer.sv */
// Top level of the midpoint ellipse rasterizer: centre registers and wiring.
// Depends on mer_pkg, mer_in_if, mer_out_if, mer_core and mer_emit.
//
//   channel   direction  transfer                       payload
//   in_if     in         in_if.valid & in_if.ready      command, radius_x, radius_y
//   out_if    out        out_if.valid & out_if.ready    pixel_x, pixel_y, last_of_step,
//                                                       ellipse_done
//   cfg_*     in         cfg_we                         cfg_index, cfg_wdata
//
// A start transfer runs three multiplier passes (rx^2, ry^2, rx^2*ry), then forms the
// decision value. A step runs accept, region test, update and handoff in that order;
// the first region-2 step inserts S_R0 to S_R5, which rebuild the decision value with
// the multiplier. The emitter sends the four pixels one per cycle while out_if.ready
// is high, so a step that follows another waits in handoff until the emitter has loaded
// all four pixels of the earlier step; out_if.ready low holds the core there too.
// Reset (rst_n low at a clock edge) leaves the block idle, centre at (512, 384).
`default_nettype none

module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CENTER_W-1:0]  cfg_wdata,
  mer_in_if.sink                    in_if,
  mer_out_if.source                 out_if
);

  logic [CENTER_W-1:0]   center_x_r;
  logic [CENTER_W-1:0]   center_y_r;
  mer_req_t              req;
  logic                  emit_ready;
  logic [COORD_BITS:0]   point_x;
  logic [COORD_BITS-1:0] point_y;

  // centre registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mer_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .req        (req),
    .point_x    (point_x),
    .point_y    (point_y),
    .emit_ready (emit_ready)
  );

  mer_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .req       (req),
    .point_x   (point_x),
    .point_y   (point_y),
    .req_ready (emit_ready),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

/* tb/midpoint_ellipse_rasterizer_tb.sv */
// Self-checking testbench for midpoint_ellipse_rasterizer: directed and random ellipse walks,
// with an in-order, transaction-level predictor of the four mirrored pixels of each step.
// Depends on mer_pkg, mer_in_if, mer_out_if and the RTL top level.
`default_nettype none

module midpoint_ellipse_rasterizer_tb import mer_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] radius_x;
    logic [COORD_BITS-1:0] radius_y;
  } ellipse_cmd_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_step;
    logic                    ellipse_done;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CENTER_W-1:0]  cfg_wdata;

  mer_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  mer_out_if out_ch ();

  midpoint_ellipse_rasterizer #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state: centre copy and the walk through one quadrant
  logic [CENTER_W-1:0] center_x_now;
  logic [CENTER_W-1:0] center_y_now;
  longint walk_x, walk_y, decision;
  longint rx_sq, ry_sq, grow_x, grow_y;
  logic   region_two;
  logic   walking;

  ellipse_cmd_t cmd_pending_q[$];
  pixel_t       pixel_expect_q[$];
  ellipse_cmd_t cmd_on_bus;

  int  cmds_queued;
  int  cmds_accepted;
  int  pixels_checked;
  int  ellipses_started;
  int  ellipses_finished;
  int  center_writes;
  int  mismatch_count;
  int  cycle_count;
  int  src_hold;
  int  sink_hold;
  bit  idle_enable;
  bit  src_bursty;
  bit  sink_bursty;

  function automatic void ellipse_reset_model();
    center_x_now = CENTER_X_RST;
    center_y_now = CENTER_Y_RST;
    walk_x = 0;
    walk_y = 0;
    decision = 0;
    rx_sq = 0;
    ry_sq = 0;
    grow_x = 0;
    grow_y = 0;
    region_two = 1'b0;
    walking = 1'b0;
  endfunction

  // advance the predicted walk by one accepted command, queue its pixels
  function automatic void ellipse_advance(input ellipse_cmd_t cmd);
    longint rx, ry, t, u, cx, cy, sx, sy;
    logic   done;
    pixel_t pix;
    if (cmd.command == CMD_START) begin
      rx = cmd.radius_x;
      ry = cmd.radius_y;
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      walk_x = 0;
      walk_y = ry;
      grow_x = 0;
      grow_y = 2 * rx_sq * ry;
      decision = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
      region_two = 1'b0;
      walking = (ry != 0);
      ellipses_started++;
      return;
    end
    if (!walking) return;
    if (walk_y == 0) begin
      walking = 1'b0;
      return;
    end
    // region switch: rebuild the decision value at the current point
    if (!region_two && grow_x >= grow_y) begin
      t = 2 * walk_x + 1;
      u = walk_y - 1;
      region_two = 1'b1;
      decision = ry_sq * t * t + 4 * rx_sq * u * u - 4 * rx_sq * ry_sq;
    end
    if (!region_two) begin
      walk_x++;
      grow_x += 2 * ry_sq;
      if (decision < 0) begin
        decision += 4 * (ry_sq + grow_x);
      end else begin
        walk_y--;
        grow_y -= 2 * rx_sq;
        decision += 4 * (ry_sq + grow_x - grow_y);
      end
    end else begin
      walk_y--;
      grow_y -= 2 * rx_sq;
      if (decision > 0) begin
        decision += 4 * (rx_sq - grow_y);
      end else begin
        walk_x++;
        grow_x += 2 * ry_sq;
        decision += 4 * (rx_sq - grow_y + grow_x);
      end
    end
    done = (walk_y == 0);
    if (done) begin
      walking = 1'b0;
      ellipses_finished++;
    end
    cx = center_x_now;
    cy = center_y_now;
    // quadrant order (+x,+y), (-x,-y), (-x,+y), (+x,-y)
    for (int k = 0; k < 4; k++) begin
      sx = (k == 0 || k == 3) ? 1 : -1;
      sy = (k == 0 || k == 2) ? 1 : -1;
      pix.pixel_x = PIX_W'(cx + sx * walk_x);
      pix.pixel_y = PIX_W'(cy + sy * walk_y);
      pix.last_of_step = (k == 3);
      pix.ellipse_done = done;
      pixel_expect_q.push_back(pix);
    end
  endfunction

  function automatic void queue_cmd(input logic command, input int rx, input int ry);
    ellipse_cmd_t c;
    c.command = command;
    c.radius_x = rx[COORD_BITS-1:0];
    c.radius_y = ry[COORD_BITS-1:0];
    cmd_pending_q.push_back(c);
    cmds_queued++;
  endfunction

  // a start followed by a run of steps with random (unused) radius bits
  function automatic void queue_walk(input int rx, input int ry, input int steps);
    queue_cmd(CMD_START, rx, ry);
    for (int i = 0; i < steps; i++)
      queue_cmd(CMD_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  // random walks until about 'target' commands that the block acts on are queued
  function automatic void queue_random_walks(input int target);
    int counted, pick, rx, ry, steps;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // complete walk on a small ellipse, a few extra steps past the end
        rx = $urandom_range(1, 16);
        ry = $urandom_range(1, 16);
        if ($urandom_range(0, 9) == 0) rx = 0;
        else if ($urandom_range(0, 9) == 0) ry = 0;
        steps = rx + ry + $urandom_range(0, 2);
        queue_walk(rx, ry, steps);
        counted += 1 + ((ry == 0) ? 0 : ((steps < rx + ry) ? steps : rx + ry));
      end else if (pick < 82) begin
        // large radii, cut short by the next start
        rx = $urandom_range(0, 1023);
        ry = $urandom_range(0, 1023);
        steps = $urandom_range(1, 12);
        queue_walk(rx, ry, steps);
        counted += 1 + ((ry == 0) ? 0 : steps);
      end else if (pick < 92) begin
        // stray steps
        for (int i = 0; i < $urandom_range(1, 3); i++)
          queue_cmd(CMD_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        // start immediately replaced
        queue_walk($urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        counted++;
      end
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ellipse_advance(cmd_on_bus);
        cmds_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_hold > 0) begin
          src_hold--;
          in_ch.valid <= 1'b0;
        end else if (cmd_pending_q.size() > 0) begin
          cmd_on_bus = cmd_pending_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.command  <= cmd_on_bus.command;
          in_ch.radius_x <= cmd_on_bus.radius_x;
          in_ch.radius_y <= cmd_on_bus.radius_y;
          if (idle_enable && src_bursty && $urandom_range(0, 3) == 0)
            src_hold = $urandom_range(1, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 63) == 0) src_bursty = !src_bursty;
    end
  end

  // pixel monitor and checker
  always @(posedge clk) begin
    pixel_t exp_pix;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected pixel exp none got x=%0d y=%0d last=%0b done=%0b", $time,
                   out_ch.pixel_x, out_ch.pixel_y, out_ch.last_of_step, out_ch.ellipse_done);
          mismatch_count++;
        end else begin
          exp_pix = pixel_expect_q.pop_front();
          pixels_checked++;
          if (out_ch.pixel_x !== exp_pix.pixel_x || out_ch.pixel_y !== exp_pix.pixel_y ||
              out_ch.last_of_step !== exp_pix.last_of_step ||
              out_ch.ellipse_done !== exp_pix.ellipse_done) begin
            $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b done=%0b", $time,
                     exp_pix.pixel_x, exp_pix.pixel_y, exp_pix.last_of_step,
                     exp_pix.ellipse_done);
            $display("%0t:                got x=%0d y=%0d last=%0b done=%0b", $time,
                     out_ch.pixel_x, out_ch.pixel_y, out_ch.last_of_step,
                     out_ch.ellipse_done);
            mismatch_count++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_enable && sink_bursty && $urandom_range(0, 5) == 0)
          sink_hold = $urandom_range(1, 9);
      end
      if ($urandom_range(0, 63) == 0) sink_bursty = !sink_bursty;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("midpoint_ellipse_rasterizer verification failed");
      $finish;
    end
  end

  // wait for every queued command to transfer and every pixel to arrive
  task automatic drain_and_settle();
    while (cmds_accepted != cmds_queued || pixel_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_center(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_we <= 1'b0;
    center_x_now = cx;
    center_y_now = cy;
    center_writes += 2;
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_START;
    in_ch.radius_x = '0;
    in_ch.radius_y = '0;
    out_ch.ready = 1'b0;
    idle_enable = 1'b1;
    src_bursty = 1'b1;
    sink_bursty = 1'b1;
    ellipse_reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: step while idle, zero radii, extremes, restart mid-walk
    queue_cmd(CMD_STEP, 1023, 1023);
    queue_walk(0, 0, 2);
    queue_walk(0, 3, 4);
    queue_walk(1023, 1023, 3);
    queue_walk(1023, 1, 3);
    queue_walk(2, 3, 6);
    drain_and_settle();

    // corner centres, then a random one with idling switched off
    set_center('0, '0);
    queue_random_walks(100);
    drain_and_settle();

    set_center('1, '1);
    queue_random_walks(100);
    drain_and_settle();

    set_center(CENTER_W'($urandom_range(0, 1023)), CENTER_W'($urandom_range(0, 1023)));
    idle_enable = 1'b0;
    queue_random_walks(100);
    drain_and_settle();

    $display("covered %0d commands, %0d ellipses started, %0d walked to the end",
             cmds_accepted, ellipses_started, ellipses_finished);
    $display("checked %0d pixels across %0d centre register writes",
             pixels_checked, center_writes);
    if (mismatch_count == 0) begin
      $display("midpoint_ellipse_rasterizer verification clean");
    end else begin
      $display("midpoint_ellipse_rasterizer verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
